@@ hdl/stuffed_frame_encoder_xor_macros.svh @@
// Assertion macros shared by the checker of the framed byte encoder
`ifndef STUFFED_FRAME_ENCODER_XOR_MACROS_SVH
`define STUFFED_FRAME_ENCODER_XOR_MACROS_SVH

// Same-cycle implication, sampled on clk and held off during reset
`define SFX_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and held off during reset
`define SFX_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/sfx_pkg.sv @@
// Package: framing symbols, queue sizing, job type and output slot codes
package sfx_pkg;

	localparam logic [7:0] SYM_STX   = 8'h02;
	localparam logic [7:0] SYM_ETX   = 8'h03;
	localparam logic [7:0] SYM_STUFF = 8'h04;
	localparam logic [7:0] SYM_ENQ   = 8'h05;
	localparam logic [7:0] SYM_ZERO  = 8'h00;

	localparam int NUM_SLOTS = 8;
	localparam int QDEPTH    = 2;
	localparam int QPTR_W    = $clog2(QDEPTH);
	localparam int QCNT_W    = $clog2(QDEPTH + 1);

	// One classified input item, as handed from front to back
	typedef struct packed {
		logic [7:0] data;
		logic       hdr;
		logic       stuff;
		logic       last;
		logic [7:0] csum;
	} job_t;

	// Position of a beat within the beats one item can produce
	typedef enum logic [2:0] {
		SLOT_HDR_STX = 3'd0,
		SLOT_HDR_ENQ = 3'd1,
		SLOT_DATA    = 3'd2,
		SLOT_STUFF   = 3'd3,
		SLOT_TRL_STX = 3'd4,
		SLOT_TRL_ETX = 3'd5,
		SLOT_CSUM    = 3'd6,
		SLOT_ZERO    = 3'd7
	} slot_t;

endpackage

@@ hdl/sfx_if.sv @@
// Interfaces: input byte channel and framed output channel
interface sfx_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface sfx_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       run_last;
	logic       frame_end;

	modport source (output valid, output out_byte, output run_last, output frame_end,
		input ready);
	modport sink   (input valid, input out_byte, input run_last, input frame_end,
		output ready);
endinterface

@@ hdl/sfx_front.sv @@
// Front end: accept input beats, track frame state and checksum, build jobs
module sfx_front (
	input  logic           clk,
	input  logic           arst_n,
	sfx_in_if.sink         in_ch,
	input  logic           q_full,
	output logic           push,
	output sfx_pkg::job_t  push_job
);

	logic       inside_q;
	logic [7:0] xor_q;
	logic [7:0] xor_base;
	logic [7:0] xor_next;

	assign in_ch.ready = !q_full;
	assign push        = in_ch.valid && !q_full;

	// Restart the checksum at ENQ on the first byte of a packet
	assign xor_base = inside_q ? xor_q : sfx_pkg::SYM_ENQ;
	assign xor_next = xor_base ^ in_ch.data_byte;

	// Classify the beat
	always_comb begin
		push_job.data  = in_ch.data_byte;
		push_job.hdr   = !inside_q;
		push_job.stuff = (in_ch.data_byte == sfx_pkg::SYM_STX);
		push_job.last  = in_ch.last_byte;
		push_job.csum  = xor_next ^ sfx_pkg::SYM_ETX;
	end

	// Advance frame state on each accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inside_q <= 1'b0;
			xor_q    <= 8'h00;
		end else if (push) begin
			inside_q <= !in_ch.last_byte;
			xor_q    <= xor_next;
		end
	end

endmodule

@@ hdl/sfx_fifo.sv @@
// Job queue between front and back, small register file with pointers
module sfx_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  sfx_pkg::job_t  push_job,
	input  logic           pop,
	output logic           full,
	output logic           head_valid,
	output sfx_pkg::job_t  head
);

	sfx_pkg::job_t                  mem_q [sfx_pkg::QDEPTH];
	logic [sfx_pkg::QPTR_W-1:0]     wr_ptr_q;
	logic [sfx_pkg::QPTR_W-1:0]     rd_ptr_q;
	logic [sfx_pkg::QCNT_W-1:0]     cnt_q;
	logic                           do_pop;

	assign full       = (cnt_q == sfx_pkg::QCNT_W'(sfx_pkg::QDEPTH));
	assign head_valid = (cnt_q != '0);
	assign head       = mem_q[rd_ptr_q];
	assign do_pop     = pop && head_valid;

	// Store the job at the write pointer
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	// Move pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + sfx_pkg::QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + sfx_pkg::QPTR_W'(1);
			end
			if (push && !do_pop) begin
				cnt_q <= cnt_q + sfx_pkg::QCNT_W'(1);
			end else if (!push && do_pop) begin
				cnt_q <= cnt_q - sfx_pkg::QCNT_W'(1);
			end
		end
	end

endmodule

@@ hdl/sfx_back.sv @@
// Back end: walk the beats of the head job into the output register
module sfx_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           head_valid,
	input  sfx_pkg::job_t  head,
	output logic           pop,
	sfx_out_if.source      out_ch
);

	logic [sfx_pkg::NUM_SLOTS-1:0] done_q;
	logic [sfx_pkg::NUM_SLOTS-1:0] need;
	logic [sfx_pkg::NUM_SLOTS-1:0] rem;
	logic [sfx_pkg::NUM_SLOTS-1:0] sel;
	logic [2:0]                    idx;
	sfx_pkg::slot_t                slot;
	logic                          load;
	logic                          final_beat;
	logic [7:0]                    beat_byte;
	logic                          valid_q;
	logic [7:0]                    byte_q;
	logic                          run_last_q;
	logic                          frame_end_q;

	// Beats this job needs, minus those already sent
	assign need = {head.last, head.last, head.last, head.last,
		head.stuff, 1'b1, head.hdr, head.hdr};
	assign rem  = need & ~done_q;

	// Pick the earliest remaining beat
	always_comb begin
		idx = 3'd0;
		for (int i = sfx_pkg::NUM_SLOTS - 1; i >= 0; i--) begin
			if (rem[i]) begin
				idx = 3'(i);
			end
		end
	end

	assign slot       = sfx_pkg::slot_t'(idx);
	assign sel        = rem & (~rem + 8'd1);
	assign final_beat = ((rem & ~sel) == '0);
	assign load       = head_valid && (!valid_q || out_ch.ready);
	assign pop        = load && final_beat;

	// Select the byte for this beat
	always_comb begin
		case (slot)
			sfx_pkg::SLOT_HDR_STX: beat_byte = sfx_pkg::SYM_STX;
			sfx_pkg::SLOT_HDR_ENQ: beat_byte = sfx_pkg::SYM_ENQ;
			sfx_pkg::SLOT_DATA:    beat_byte = head.data;
			sfx_pkg::SLOT_STUFF:   beat_byte = sfx_pkg::SYM_STUFF;
			sfx_pkg::SLOT_TRL_STX: beat_byte = sfx_pkg::SYM_STX;
			sfx_pkg::SLOT_TRL_ETX: beat_byte = sfx_pkg::SYM_ETX;
			sfx_pkg::SLOT_CSUM:    beat_byte = head.csum;
			sfx_pkg::SLOT_ZERO:    beat_byte = sfx_pkg::SYM_ZERO;
			default:               beat_byte = sfx_pkg::SYM_ZERO;
		endcase
	end

	// Track sent beats of the head job, clear on pop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= '0;
		end else if (load) begin
			done_q <= final_beat ? '0 : (done_q | sel);
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			valid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (load) begin
			byte_q      <= beat_byte;
			run_last_q  <= final_beat;
			frame_end_q <= (slot == sfx_pkg::SLOT_ZERO);
		end
	end

	assign out_ch.valid     = valid_q;
	assign out_ch.out_byte  = byte_q;
	assign out_ch.run_last  = run_last_q;
	assign out_ch.frame_end = frame_end_q;

endmodule

@@ hdl/stuffed_frame_encoder_xor.sv @@
// Top level: STX/ETX framing encoder with byte stuffing and XOR checksum
//
//  channel | dir | beat contents                         | accept
//  in_ch   | in  | data_byte[7:0], last_byte             | valid && ready
//  out_ch  | out | out_byte[7:0], run_last, frame_end    | valid && ready
//
// The back end sends one output beat per cycle unless out_ch stalls; an item
// makes 1-8 beats (header 2, data 1, stuff 1, trailer 4), plain bytes 1 or 3.
// A 2-entry job queue lets the front accept an item every cycle it has room.
// The output register stalls the back end only; backpressure reaches the
// input once the queue fills. Reset clears the frame flag, checksum, queue
// and output valid.
module stuffed_frame_encoder_xor (
	input  logic       clk,
	input  logic       arst_n,
	sfx_in_if.sink     in_ch,
	sfx_out_if.source  out_ch
);

	logic           push;
	logic           pop;
	logic           q_full;
	logic           head_valid;
	sfx_pkg::job_t  push_job;
	sfx_pkg::job_t  head;

	sfx_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_ch),
		.q_full   (q_full),
		.push     (push),
		.push_job (push_job)
	);

	sfx_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.pop        (pop),
		.full       (q_full),
		.head_valid (head_valid),
		.head       (head)
	);

	sfx_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.out_ch     (out_ch)
	);

endmodule

@@ hdl/sfx_checker.sv @@
// Port checker for the framed byte encoder, bound to the top level
`include "stuffed_frame_encoder_xor_macros.svh"

module sfx_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic       run_last,
	input logic       frame_end
);

	logic [3:0] open_q;
	logic       in_acc;
	logic       out_done;

	assign in_acc   = in_valid && in_ready;
	assign out_done = out_valid && out_ready && run_last;

	// Count items accepted whose last beat has not gone out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= 4'd0;
		end else if (in_acc && !out_done) begin
			open_q <= open_q + 4'd1;
		end else if (!in_acc && out_done) begin
			open_q <= open_q - 4'd1;
		end
	end

	`SFX_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_byte), "stalled output beat changed")
	`SFX_ASSERT_NOW(a_end_is_last, out_valid && frame_end, run_last, "frame end not last beat of item")
	`SFX_ASSERT_NOW(a_end_is_zero, out_valid && frame_end, out_byte == 8'h00, "frame end byte not zero")
	`SFX_ASSERT_NOW(a_no_orphan, out_done, open_q != 4'd0, "item completed with none outstanding")

endmodule

bind stuffed_frame_encoder_xor sfx_checker u_sfx_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_byte  (out_ch.out_byte),
	.run_last  (out_ch.run_last),
	.frame_end (out_ch.frame_end)
);

@@ test/stuffed_frame_encoder_xor_test.sv @@
// Testbench for the STX/ETX framing encoder with byte stuffing and XOR checksum
`timescale 1ns / 100ps

module stuffed_frame_encoder_xor_test;

	localparam int STALL_LIMIT = 1000;	// cycles with no beat accepted on either side
	localparam int ITEM_TARGET = 430;
	localparam int TAIL_ITEMS  = 40;	// last items go out with no idling
	localparam int HOLD_AT     = 200;	// output beats seen before the long hold-off
	localparam int HOLD_LEN    = 150;
	localparam int DRAIN_WAIT  = 16;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} pkt_byte_t;

	typedef struct packed {
		logic [7:0] ob;
		logic       run_last;
		logic       frame_end;
	} line_beat_t;

	logic clk;
	logic arst_n;

	sfx_in_if  in_ch ();
	sfx_out_if out_ch ();

	stuffed_frame_encoder_xor dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	pkt_byte_t  pending_bytes[$];
	line_beat_t line_expect[$];

	// Own copy of the encoder state
	logic       frame_open;
	logic [7:0] xor_acc;

	int         mismatches;
	int         out_count;
	int         idle_cycles;
	logic       in_took;
	int         in_gap;
	int         out_gap;
	int         hold_left;
	logic       held_once;
	logic       quiet_tail;
	pkt_byte_t  next_byte;

	// Clock
	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Queue the line beats that one input byte produces
	function automatic void frame_byte(input logic [7:0] d, input logic lst);
		line_beat_t run[$];
		if (!frame_open) begin
			run.push_back('{sfx_pkg::SYM_STX, 1'b0, 1'b0});
			run.push_back('{sfx_pkg::SYM_ENQ, 1'b0, 1'b0});
			xor_acc = sfx_pkg::SYM_ENQ;
			frame_open = 1'b1;
		end
		run.push_back('{d, 1'b0, 1'b0});
		if (d == sfx_pkg::SYM_STX)
			run.push_back('{sfx_pkg::SYM_STUFF, 1'b0, 1'b0});
		xor_acc = xor_acc ^ d;
		if (lst) begin
			run.push_back('{sfx_pkg::SYM_STX, 1'b0, 1'b0});
			run.push_back('{sfx_pkg::SYM_ETX, 1'b0, 1'b0});
			run.push_back('{xor_acc ^ sfx_pkg::SYM_ETX, 1'b0, 1'b0});
			run.push_back('{sfx_pkg::SYM_ZERO, 1'b0, 1'b1});
			frame_open = 1'b0;
		end
		run[run.size() - 1].run_last = 1'b1;
		foreach (run[i])
			line_expect.push_back(run[i]);
	endfunction

	task automatic flag_mismatch(input string why, input logic have_want, input line_beat_t want,
		input line_beat_t got);
		mismatches++;
		if (mismatches <= 10) begin
			if (have_want)
				$display("%0t: %s: expected %02h/%b/%b, got %02h/%b/%b (byte/run_last/frame_end)",
					$time, why, want.ob, want.run_last, want.frame_end,
					got.ob, got.run_last, got.frame_end);
			else
				$display("%0t: %s: got byte %02h run_last %b frame_end %b",
					$time, why, got.ob, got.run_last, got.frame_end);
		end
	endtask

	task automatic add_byte(input logic [7:0] d, input logic lst);
		pending_bytes.push_back('{d, lst});
	endtask

	// Sample both channels: predict on input beats, check output beats
	always @(posedge clk) begin
		line_beat_t got;
		line_beat_t want;
		if (arst_n) begin
			in_took <= in_ch.valid && in_ch.ready;
			if (in_ch.valid && in_ch.ready)
				frame_byte(in_ch.data_byte, in_ch.last_byte);
			if (out_ch.valid && out_ch.ready) begin
				out_count <= out_count + 1;
				got = '{out_ch.out_byte, out_ch.run_last, out_ch.frame_end};
				if (line_expect.size() == 0) begin
					flag_mismatch("unexpected beat", 1'b0, got, got);
				end else begin
					want = line_expect.pop_front();
					if (got.ob !== want.ob || got.run_last !== want.run_last
						|| got.frame_end !== want.frame_end)
						flag_mismatch("wrong beat", 1'b1, want, got);
				end
			end
		end
	end

	// Watchdog: end the run when nothing moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	// Input driver: hold the beat until taken, then idle or present the next byte
	always @(negedge clk) begin
		if (arst_n) begin
			if (pending_bytes.size() < TAIL_ITEMS)
				quiet_tail <= 1'b1;
			if (in_ch.valid && !in_took) begin
				// hold current beat
			end else if (in_gap > 0) begin
				in_gap <= in_gap - 1;
				in_ch.valid <= 1'b0;
			end else if (pending_bytes.size() == 0) begin
				in_ch.valid <= 1'b0;
			end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
				in_gap <= $urandom_range(0, 6);
				in_ch.valid <= 1'b0;
			end else begin
				next_byte = pending_bytes.pop_front();
				in_ch.data_byte <= next_byte.data;
				in_ch.last_byte <= next_byte.last;
				in_ch.valid <= 1'b1;
			end
		end
	end

	// Output receiver: random stalls plus one long hold-off to back up the block
	always @(negedge clk) begin
		if (arst_n) begin
			if (!held_once && out_count >= HOLD_AT) begin
				held_once <= 1'b1;
				hold_left <= HOLD_LEN;
				out_ch.ready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				out_ch.ready <= 1'b0;
			end else if (out_gap > 0) begin
				out_gap <= out_gap - 1;
				out_ch.ready <= 1'b0;
			end else if (!quiet_tail && $urandom_range(0, 4) == 0) begin
				out_gap <= $urandom_range(0, 6);
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	// Stimulus, reset and end of run
	initial begin
		int plen;
		logic [7:0] d;
		in_ch.valid = 1'b0;
		in_ch.data_byte = '0;
		in_ch.last_byte = 1'b0;
		out_ch.ready = 1'b0;
		frame_open = 1'b0;
		xor_acc = '0;
		mismatches = 0;
		out_count = 0;
		idle_cycles = 0;
		in_took = 1'b0;
		in_gap = 0;
		out_gap = 0;
		hold_left = 0;
		held_once = 1'b0;
		quiet_tail = 1'b0;
		arst_n = 1'b0;

		// Multi-byte packet with extremes and a stuffed byte inside
		add_byte(8'h00, 1'b0);
		add_byte(8'hFF, 1'b0);
		add_byte(sfx_pkg::SYM_STX, 1'b0);
		add_byte(8'h55, 1'b1);
		// Single-byte packets; 0x02 with last puts stuffing before the trailer
		add_byte(sfx_pkg::SYM_STX, 1'b1);
		add_byte(8'hAA, 1'b1);
		add_byte(8'h00, 1'b1);
		add_byte(8'hFF, 1'b1);
		// Checksum byte equal to STX goes out unstuffed
		add_byte(8'h04, 1'b1);
		add_byte(8'h10, 1'b0);
		add_byte(8'h14, 1'b1);
		// Back-to-back stuffing
		add_byte(sfx_pkg::SYM_STX, 1'b0);
		add_byte(sfx_pkg::SYM_STX, 1'b0);
		add_byte(sfx_pkg::SYM_STX, 1'b1);
		// Payload that looks like framing symbols
		add_byte(sfx_pkg::SYM_ETX, 1'b0);
		add_byte(sfx_pkg::SYM_ENQ, 1'b0);
		add_byte(sfx_pkg::SYM_STUFF, 1'b0);
		add_byte(8'h01, 1'b1);

		// Random packets, mostly short, a few long
		while (pending_bytes.size() < ITEM_TARGET) begin
			plen = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
			for (int k = 0; k < plen; k++) begin
				case ($urandom_range(0, 7))
					0: d = sfx_pkg::SYM_STX;
					1: d = 8'($urandom_range(3, 5));
					default: d = 8'($urandom_range(0, 255));
				endcase
				add_byte(d, k == plen - 1);
			end
		end

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Drain: all bytes taken, all beats seen, then a short settle
		while (pending_bytes.size() != 0 || in_ch.valid) @(posedge clk);
		while (line_expect.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
